[rtl/brightness_curve_to_pwm_defines.svh]
`ifndef BRIGHTNESS_CURVE_TO_PWM_DEFINES_SVH
`define BRIGHTNESS_CURVE_TO_PWM_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold on that clock edge.
`define BCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle check: when ante holds, cons must hold on the following edge.
`define BCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bcp_pkg.sv]
`timescale 1ns / 1ps

package bcp_pkg;

  localparam int FRAC_W = 8;
  localparam int LEVEL_IN_W = 16;
  localparam int LVL_W = 15;
  localparam int IDX_W = 7;
  localparam int BYTE_W = 8;
  localparam int ROM_W = 10;
  localparam int TABLE_DEPTH = 101;

  localparam logic [IDX_W-1:0] TOP_INDEX = 7'd100;
  localparam logic [BYTE_W-1:0] DISABLE_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] RESET_BYTE = 8'hFF;

  localparam int LIMIT_INT = 100 * (2 ** FRAC_W);
  localparam logic [LEVEL_IN_W-1:0] LEVEL_LIMIT = LEVEL_IN_W'(LIMIT_INT);

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Translation interpolation result, in units of 2^-FRAC_W of a table byte.
  localparam int XL_W = BYTE_W + FRAC_W;

  // Scaling by 100/255: multiply by 100*floor(2^23/255), shift right 23,
  // then correct the quotient upward by at most one.
  localparam int SCALE_MUL = 100;
  localparam int SCALE_DIV = 255;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP = SCALE_MUL * ((2 ** RECIP_SHIFT) / SCALE_DIV);
  localparam int RECIP_W = 22;
  localparam int PROD_W = XL_W + RECIP_W;
  localparam int SCALED_W = XL_W + 7;

  // Calibration interpolation result, in units of 2^-FRAC_W of a ROM step.
  localparam int CAL_W = ROM_W + FRAC_W;

  localparam logic [ROM_W-1:0] CAL_ROM [0:TABLE_DEPTH-1] = '{
    10'd119, 10'd199, 10'd265, 10'd325, 10'd376, 10'd421, 10'd462, 10'd498,
    10'd528, 10'd559, 10'd584, 10'd607, 10'd629, 10'd650, 10'd668, 10'd683,
    10'd700, 10'd714, 10'd727, 10'd740, 10'd752, 10'd763, 10'd773, 10'd783,
    10'd792, 10'd801, 10'd809, 10'd817, 10'd824, 10'd831, 10'd837, 10'd844,
    10'd850, 10'd856, 10'd861, 10'd866, 10'd871, 10'd876, 10'd881, 10'd885,
    10'd890, 10'd894, 10'd898, 10'd902, 10'd905, 10'd909, 10'd912, 10'd916,
    10'd919, 10'd922, 10'd925, 10'd928, 10'd931, 10'd933, 10'd936, 10'd938,
    10'd941, 10'd943, 10'd946, 10'd948, 10'd950, 10'd952, 10'd954, 10'd956,
    10'd958, 10'd960, 10'd962, 10'd964, 10'd966, 10'd967, 10'd969, 10'd971,
    10'd972, 10'd974, 10'd975, 10'd977, 10'd978, 10'd980, 10'd981, 10'd982,
    10'd984, 10'd985, 10'd986, 10'd988, 10'd989, 10'd990, 10'd991, 10'd992,
    10'd993, 10'd995, 10'd996, 10'd997, 10'd998, 10'd999, 10'd1000, 10'd1001,
    10'd1002, 10'd1003, 10'd1004, 10'd1004, 10'd1005
  };

  typedef struct packed {
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } split_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [FRAC_W-1:0] frac;
  } conv_ctx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lo_byte;
    logic [BYTE_W-1:0] hi_byte;
    logic              xlate_on;
  } table_rd_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] trans;
  } level_pair_t;

  // Integer part picks the lower point; the upper one is the next entry, held at the top entry.
  function automatic split_t split_level(input logic [LVL_W-1:0] level);
    logic [IDX_W-1:0] ip;
    split_t s;
    ip = IDX_W'(level >> FRAC_W);
    if (ip > TOP_INDEX) begin
      ip = TOP_INDEX;
    end
    s.lo = ip;
    s.hi = (ip >= TOP_INDEX) ? TOP_INDEX : ip + IDX_W'(1);
    s.frac = level[FRAC_W-1:0];
    return s;
  endfunction

  function automatic logic [ROM_W-1:0] cal_rom_value(input logic [IDX_W-1:0] idx);
    return (idx > TOP_INDEX) ? CAL_ROM[TOP_INDEX] : CAL_ROM[idx];
  endfunction

endpackage

[rtl/bcp_table.sv]
`timescale 1ns / 1ps
`include "brightness_curve_to_pwm_defines.svh"

module bcp_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [bcp_pkg::IDX_W-1:0] wr_addr,
  input  logic [bcp_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [bcp_pkg::IDX_W-1:0] rd_addr_lo,
  input  logic [bcp_pkg::IDX_W-1:0] rd_addr_hi,
  output bcp_pkg::table_rd_t        rd
);
  import bcp_pkg::*;

  logic [BYTE_W-1:0] mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld;
  logic entry0_on;
  logic [BYTE_W-1:0] lo_data;
  logic [BYTE_W-1:0] hi_data;
  logic lo_vld;
  logic hi_vld;
  logic xlate_on;

  // Each conversion reads its address pair in the cycle it is accepted, and
  // only one word is taken per cycle, so a read never meets a write to the
  // same entry on one edge: later reads see every earlier write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      lo_data <= mem[rd_addr_lo];
      hi_data <= mem[rd_addr_hi];
      lo_vld <= vld[rd_addr_lo];
      hi_vld <= vld[rd_addr_hi];
      xlate_on <= entry0_on;
    end
  end

  // Entries never written since reset read as the reset byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      entry0_on <= 1'b0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
      if (wr_addr == '0) begin
        entry0_on <= (wr_data != DISABLE_MARK);
      end
    end
  end

  assign rd.lo_byte = lo_vld ? lo_data : RESET_BYTE;
  assign rd.hi_byte = hi_vld ? hi_data : RESET_BYTE;
  assign rd.xlate_on = xlate_on;

  `BCP_ASSERT_NEXT(a_entry0_track, wr_en && (wr_addr == '0), entry0_on == ($past(wr_data) != DISABLE_MARK), "translation enable does not follow entry 0")

endmodule

[rtl/bcp_xlate.sv]
`timescale 1ns / 1ps
`include "brightness_curve_to_pwm_defines.svh"

module bcp_xlate (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 acc,
  input  bcp_pkg::conv_ctx_t   ctx,
  input  bcp_pkg::table_rd_t   rd,
  output logic                 in_rdy,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcp_pkg::level_pair_t out_data
);
  import bcp_pkg::*;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [LVL_W-1:0] lvl1, lvl2, lvl3;
  logic [FRAC_W-1:0] frac1;
  logic ten2, ten3;
  logic [XL_W-1:0] full2;
  logic [LVL_W-1:0] q3;
  logic [SCALED_W-1:0] scaled3;

  logic up1;
  logic [BYTE_W-1:0] dmag1;
  logic [XL_W-1:0] base1, prod1, full1;
  logic [PROD_W-1:0] recip2;
  logic [SCALED_W-1:0] scaled2;
  logic [SCALED_W-1:0] rem3;
  logic [LVL_W-1:0] qc3, qsat3;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_rdy = rdy1;

  // Stage 1: exact interpolation between the two table bytes.
  always_comb begin
    up1 = rd.hi_byte >= rd.lo_byte;
    dmag1 = up1 ? (rd.hi_byte - rd.lo_byte) : (rd.lo_byte - rd.hi_byte);
    base1 = {rd.lo_byte, {FRAC_W{1'b0}}};
    prod1 = XL_W'(dmag1) * XL_W'(frac1);
    full1 = up1 ? (base1 + prod1) : (base1 - prod1);
  end

  // Stage 2: quotient estimate by reciprocal, never above the true one.
  assign recip2 = PROD_W'(full2) * PROD_W'(RECIP);
  assign scaled2 = SCALED_W'(full2) * SCALED_W'(SCALE_MUL);

  // Stage 3: one correction step and a clamp to the level limit, then choose translated or plain level.
  always_comb begin
    rem3 = scaled3 - SCALED_W'(q3) * SCALED_W'(SCALE_DIV);
    qc3 = (rem3 >= SCALED_W'(SCALE_DIV)) ? q3 + LVL_W'(1) : q3;
    qsat3 = (qc3 > LVL_W'(LEVEL_LIMIT)) ? LVL_W'(LEVEL_LIMIT) : qc3;
    out_data.level = lvl3;
    out_data.trans = ten3 ? qsat3 : lvl3;
  end

  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= acc;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && acc) begin
      lvl1 <= ctx.level;
      frac1 <= ctx.frac;
    end
    if (rdy2) begin
      lvl2 <= lvl1;
      ten2 <= rd.xlate_on;
      full2 <= full1;
    end
    if (rdy3) begin
      lvl3 <= lvl2;
      ten3 <= ten2;
      q3 <= LVL_W'(recip2 >> RECIP_SHIFT);
      scaled3 <= scaled2;
    end
  end

  `BCP_ASSERT_NOW(a_single_correction, v3, rem3 < SCALED_W'(2 * SCALE_DIV), "reciprocal quotient is off by more than one")
  `BCP_ASSERT_NOW(a_scaled_in_range, v3 && ten3, qc3 <= LVL_W'(LEVEL_LIMIT), "translated level exceeds 100 percent")

endmodule

[rtl/bcp_cal.sv]
`timescale 1ns / 1ps
`include "brightness_curve_to_pwm_defines.svh"

module bcp_cal #(
  parameter int PWM_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_rdy,
  input  bcp_pkg::level_pair_t      in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PWM_BITS-1:0]       duty_value,
  output logic [bcp_pkg::LVL_W-1:0] reported_level,
  output logic [bcp_pkg::LVL_W-1:0] translated_level
);
  import bcp_pkg::*;

  localparam int EXT_W = CAL_W + PWM_BITS;

  logic v4, v5;
  logic rdy4, rdy5, rdy6;

  logic [LVL_W-1:0] lvl4, trans4, lvl5, trans5;
  logic [ROM_W-1:0] c5, dd5;
  logic [FRAC_W-1:0] frac5;

  split_t sp4;
  logic [ROM_W-1:0] rom_lo4, rom_hi4;
  logic [CAL_W-1:0] full5;
  logic [EXT_W-1:0] ext5;

  assign rdy6 = !out_valid || out_ready;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign in_rdy = rdy4;

  // Stage 4: calibration points around the level.
  always_comb begin
    sp4 = split_level(trans4);
    rom_lo4 = cal_rom_value(sp4.lo);
    rom_hi4 = cal_rom_value(sp4.hi);
  end

  // Stage 5: the calibration curve never falls, so the step is unsigned.
  always_comb begin
    full5 = {c5, {FRAC_W{1'b0}}} + CAL_W'(dd5) * CAL_W'(frac5);
    ext5 = {full5, {PWM_BITS{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy4) begin
        v4 <= in_valid;
      end
      if (rdy5) begin
        v5 <= v4;
      end
      if (rdy6) begin
        out_valid <= v5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      lvl4 <= in_data.level;
      trans4 <= in_data.trans;
    end
    if (rdy5) begin
      lvl5 <= lvl4;
      trans5 <= trans4;
      c5 <= rom_lo4;
      dd5 <= rom_hi4 - rom_lo4;
      frac5 <= sp4.frac;
    end
    if (rdy6) begin
      duty_value <= ext5[EXT_W-1 -: PWM_BITS];
      reported_level <= lvl5;
      translated_level <= trans5;
    end
  end

  `BCP_ASSERT_NOW(a_rom_rising, v4, rom_hi4 >= rom_lo4, "calibration points out of order")

endmodule

[rtl/brightness_curve_to_pwm.sv]
// Throughput: one word per cycle while out_ready does not hold the output back;
// a conversion word passes through six registered pipeline stages, and the
// translation table is read at both points in the accept cycle.
// A load word writes the table in its accept cycle and gives no result.
// Reset (rst, synchronous) empties the pipeline and clears the table's valid
// bits, so every entry reads 255 and translation is off; input is held off.
`timescale 1ns / 1ps

module brightness_curve_to_pwm #(
  parameter int PWM_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [bcp_pkg::LEVEL_IN_W-1:0] level_in,
  input  logic [bcp_pkg::IDX_W-1:0]      entry_index,
  input  logic [bcp_pkg::BYTE_W-1:0]     entry_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [PWM_BITS-1:0]            duty_value,
  output logic [bcp_pkg::LVL_W-1:0]      reported_level,
  output logic [bcp_pkg::LVL_W-1:0]      translated_level
);
  import bcp_pkg::*;

  logic accept;
  logic acc_conv;
  logic wr_en;
  logic [LEVEL_IN_W-1:0] level_sat;
  split_t sp;
  conv_ctx_t ctx;
  table_rd_t rd;
  logic xl_rdy;
  logic xl_valid;
  logic cal_rdy;
  level_pair_t xl_data;

  assign in_ready = xl_rdy && !rst;
  assign accept = in_valid && in_ready;
  assign acc_conv = accept && (operation == OP_CONVERT);
  // Writes beyond the last entry are dropped.
  assign wr_en = accept && (operation == OP_LOAD) && (entry_index <= TOP_INDEX);

  always_comb begin
    level_sat = (level_in > LEVEL_LIMIT) ? LEVEL_LIMIT : level_in;
    sp = split_level(LVL_W'(level_sat));
    ctx.level = LVL_W'(level_sat);
    ctx.frac = sp.frac;
  end

  bcp_table u_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (entry_index),
    .wr_data    (entry_value),
    .rd_en      (acc_conv),
    .rd_addr_lo (sp.lo),
    .rd_addr_hi (sp.hi),
    .rd         (rd)
  );

  bcp_xlate u_xlate (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc_conv),
    .ctx       (ctx),
    .rd        (rd),
    .in_rdy    (xl_rdy),
    .out_valid (xl_valid),
    .out_ready (cal_rdy),
    .out_data  (xl_data)
  );

  bcp_cal #(
    .PWM_BITS (PWM_BITS)
  ) u_cal (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (xl_valid),
    .in_rdy           (cal_rdy),
    .in_data          (xl_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .duty_value       (duty_value),
    .reported_level   (reported_level),
    .translated_level (translated_level)
  );

endmodule
